[sv/bpc_pkg.sv]
// bpc_pkg: shared types, widths and command codes of the box point counter
// used by the channel interfaces and every module of the block; no dependencies
package bpc_pkg;

    localparam int DIMENSIONS     = 4;
    localparam int INDEX_BITS     = 12;
    localparam int CMD_W          = 2;
    localparam int ORDER_W        = 2;
    localparam int COUNT_W        = 9;
    localparam int DEF_MAX_POINTS = 256;
    localparam int APB_AW         = 4;
    localparam int APB_DW         = 32;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_GROW  = 2'd3;

    typedef logic [INDEX_BITS-1:0] t_index;
    typedef t_index [DIMENSIONS-1:0] t_point;
    typedef logic [DIMENSIONS-1:0][ORDER_W-1:0] t_order;

    localparam t_index TOP_RESET = 12'hFFF;

endpackage

[sv/bpc_if.sv]
// bpc_if: valid/ready channel interfaces for command items and result items
// depends on bpc_pkg for field widths
interface bpc_in_if;
    import bpc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    t_index               corner_0;
    t_index               corner_1;
    t_index               corner_2;
    t_index               corner_3;
    logic [ORDER_W-1:0]   order_0;
    logic [ORDER_W-1:0]   order_1;
    logic [ORDER_W-1:0]   order_2;
    logic [ORDER_W-1:0]   order_3;

    modport source (
        output valid, command, corner_0, corner_1, corner_2, corner_3,
               order_0, order_1, order_2, order_3,
        input  ready
    );
    modport sink (
        input  valid, command, corner_0, corner_1, corner_2, corner_3,
               order_0, order_1, order_2, order_3,
        output ready
    );
endinterface

interface bpc_out_if;
    import bpc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 status;
    logic [COUNT_W-1:0]   open_count;
    logic [COUNT_W-1:0]   closed_count;
    t_index               box_0;
    t_index               box_1;
    t_index               box_2;
    t_index               box_3;

    modport source (
        output valid, status, open_count, closed_count, box_0, box_1, box_2, box_3,
        input  ready
    );
    modport sink (
        input  valid, status, open_count, closed_count, box_0, box_1, box_2, box_3,
        output ready
    );
endinterface

[sv/bpc_regs.sv]
// bpc_regs: APB-style register file holding the per-dimension top index
// depends on bpc_pkg for widths and reset value
module bpc_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bpc_pkg::APB_AW-1:0] paddr,
    input  logic [bpc_pkg::APB_DW-1:0] pwdata,
    output logic [bpc_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output bpc_pkg::t_point            o_top
);
    import bpc_pkg::*;

    t_point          r_top;
    logic [1:0]      w_idx;

    assign w_idx  = paddr[APB_AW-1:2];
    assign pready = 1'b1;
    assign prdata = APB_DW'(r_top[w_idx]);
    assign o_top  = r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < DIMENSIONS; d++) begin
                r_top[d] <= TOP_RESET;
            end
        end else if (psel && penable && pwrite) begin
            r_top[w_idx] <= pwdata[INDEX_BITS-1:0];
        end
    end

endmodule

[sv/bpc_store.sv]
// bpc_store: point memory, one write port and one registered read port
// depends on bpc_pkg for the point type
module bpc_store #(
    parameter int MAX_POINTS = bpc_pkg::DEF_MAX_POINTS
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] i_wr_addr,
    input  bpc_pkg::t_point          i_wr_data,
    input  logic                     i_rd_en,
    input  logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] i_rd_addr,
    output bpc_pkg::t_point          o_rd_data
);
    import bpc_pkg::*;

    t_point r_mem [MAX_POINTS];
    t_point r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/bpc_core.sv]
// bpc_core: command sequencer, store scan, box evaluation and result register
// depends on bpc_pkg and the bpc_if channel interfaces; drives bpc_store
module bpc_core #(
    parameter int MAX_POINTS = bpc_pkg::DEF_MAX_POINTS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    bpc_in_if.sink                   i_in,
    bpc_out_if.source                o_out,
    input  bpc_pkg::t_point          i_top,
    output logic                     o_wr_en,
    output logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] o_wr_addr,
    output bpc_pkg::t_point          o_wr_data,
    output logic                     o_rd_en,
    output logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] o_rd_addr,
    input  bpc_pkg::t_point          i_rd_data
);
    import bpc_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_POINTS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_idx;
    logic              r_rd_vld;
    logic [CMD_W-1:0]  r_cmd;
    t_point            r_corner;
    t_order            r_order;
    t_point            r_box;
    logic [CW-1:0]     r_open;
    logic [CW-1:0]     r_closed;
    logic              r_status;
    logic              r_out_valid;
    logic              r_o_status;
    logic [COUNT_W-1:0] r_o_open;
    logic [COUNT_W-1:0] r_o_closed;
    t_point            r_o_box;

    t_point            w_corner;
    t_order            w_order;
    logic              w_acc;
    logic              w_full;
    logic              w_issue;
    logic              w_out_free;

    t_point            n_box;
    logic [CW-1:0]     n_open;
    logic [CW-1:0]     n_closed;
    logic              w_is_open;
    logic              w_is_closed;
    logic              w_memo_v;
    logic [ORDER_W-1:0] w_memo_d;
    logic              w_stop;
    t_index            w_k;
    logic [ORDER_W-1:0] w_cd;

    assign w_corner = {i_in.corner_3, i_in.corner_2, i_in.corner_1, i_in.corner_0};
    assign w_order  = {i_in.order_3, i_in.order_2, i_in.order_1, i_in.order_0};

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_full     = (r_cnt == FULL);
    assign w_issue    = (r_state == ST_SCAN) && (r_idx < r_cnt);
    assign w_out_free = !r_out_valid || o_out.ready;

    // loads go straight into the store at the transfer
    assign o_wr_en   = w_acc && (i_in.command == CMD_LOAD) && !w_full;
    assign o_wr_addr = r_cnt[AW-1:0];
    assign o_wr_data = w_corner;
    assign o_rd_en   = w_issue;
    assign o_rd_addr = r_idx[AW-1:0];

    // evaluate the point that the store returned this cycle
    always_comb begin
        n_box       = r_box;
        n_open      = r_open;
        n_closed    = r_closed;
        w_is_open   = 1'b1;
        w_is_closed = 1'b1;
        w_memo_v    = 1'b0;
        w_memo_d    = '0;
        w_stop      = 1'b0;
        w_k         = '0;
        w_cd        = '0;
        for (int d = 0; d < DIMENSIONS; d++) begin
            if (i_rd_data[d] >= r_corner[d]) begin
                w_is_open = 1'b0;
            end
            if (i_rd_data[d] > r_corner[d]) begin
                w_is_closed = 1'b0;
            end
        end
        // memo rule: first dimension that can shrink, unless some dimension blocks
        for (int j = 0; j < DIMENSIONS; j++) begin
            w_cd = r_order[j];
            w_k  = i_rd_data[w_cd];
            if (!w_stop && (w_k >= r_corner[w_cd])) begin
                if (w_k < r_box[w_cd]) begin
                    if (!w_memo_v) begin
                        w_memo_v = 1'b1;
                        w_memo_d = w_cd;
                    end
                end else begin
                    w_memo_v = 1'b0;
                    w_stop   = 1'b1;
                end
            end
        end
        if (r_rd_vld) begin
            if (r_cmd == CMD_QUERY) begin
                if (w_is_open) begin
                    n_open = CW'(r_open + 1'b1);
                end
                if (w_is_closed) begin
                    n_closed = CW'(r_closed + 1'b1);
                    for (int d = 0; d < DIMENSIONS; d++) begin
                        if (i_rd_data[d] > r_box[d]) begin
                            n_box[d] = i_rd_data[d];
                        end
                    end
                end
            end else if (w_memo_v) begin
                n_box[w_memo_d] = i_rd_data[w_memo_d];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
            if (w_issue) begin
                r_idx <= CW'(r_idx + 1'b1);
            end
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_idx <= '0;
                        if (i_in.command == CMD_CLEAR) begin
                            r_cnt <= '0;
                        end else if ((i_in.command == CMD_LOAD) && !w_full) begin
                            r_cnt <= CW'(r_cnt + 1'b1);
                        end
                        if ((i_in.command == CMD_QUERY) || (i_in.command == CMD_GROW)) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_SCAN: begin
                    if (!w_issue && !r_rd_vld) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // payload side, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cmd    <= i_in.command;
            r_corner <= w_corner;
            r_order  <= w_order;
            r_status <= (i_in.command == CMD_LOAD) && w_full;
            r_open   <= '0;
            r_closed <= '0;
            if (i_in.command == CMD_GROW) begin
                r_box <= i_top;
            end else begin
                r_box <= '0;
            end
        end else begin
            r_box    <= n_box;
            r_open   <= n_open;
            r_closed <= n_closed;
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_o_status <= r_status;
            r_o_open   <= COUNT_W'(r_open);
            r_o_closed <= COUNT_W'(r_closed);
            r_o_box    <= r_box;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_o_status;
    assign o_out.open_count   = r_o_open;
    assign o_out.closed_count = r_o_closed;
    assign o_out.box_0        = r_o_box[0];
    assign o_out.box_1        = r_o_box[1];
    assign o_out.box_2        = r_o_box[2];
    assign o_out.box_3        = r_o_box[3];

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL)
        else $error("point count beyond store depth");

    a_rd_below_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |-> ((r_state == ST_SCAN) && (r_idx < r_cnt)))
        else $error("store read past the stored points");

    a_drop_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_in.command == CMD_LOAD) && w_full) |=> (r_status && !o_wr_en))
        else $error("dropped load not flagged");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && w_out_free) |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("finished result not moved to output register");
`endif

endmodule

[sv/box_point_count_snap_grow.sv]
// Box point counter: keeps up to MAX_POINTS grid points in a single-port-read memory and
// answers clear, load, query (open and closed box counts plus snapped corner) and grow
// (memo rule from the top index registers) commands, one result per command. Clear and
// load pass from the transfer through the done state to the output register; query and
// grow first scan the stored points, the store returning one point per cycle and the box
// register updating once per point. The next command is taken while a result waits in
// the output register. The store needs no clearing pass after reset. Top index registers
// sit at byte address 4*d.
module box_point_count_snap_grow #(
    parameter int MAX_POINTS = bpc_pkg::DEF_MAX_POINTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bpc_in_if.sink                     i_in,
    bpc_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bpc_pkg::APB_AW-1:0] paddr,
    input  logic [bpc_pkg::APB_DW-1:0] pwdata,
    output logic [bpc_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import bpc_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    t_point          w_top;
    logic            w_wr_en;
    logic [AW-1:0]   w_wr_addr;
    t_point          w_wr_data;
    logic            w_rd_en;
    logic [AW-1:0]   w_rd_addr;
    t_point          w_rd_data;

    bpc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_top   (w_top)
    );

    bpc_store #(
        .MAX_POINTS (MAX_POINTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    bpc_core #(
        .MAX_POINTS (MAX_POINTS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .i_top     (w_top),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data)
    );

endmodule

[tb/bpc_checker.sv]
// bpc_checker: scoreboard for the box point counter; keeps its own point store and
// top index copies, predicts one result per command transfer and compares results
// depends on bpc_pkg and the channel interfaces in bpc_if
module bpc_checker
    import bpc_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int REG_STRIDE = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bpc_in_if                 i_cmd_ch,
    bpc_out_if                i_res_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                o_error_count,
    output int                o_pending,
    output int                o_checked
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic               status;
        logic [COUNT_W-1:0] open_n;
        logic [COUNT_W-1:0] closed_n;
        t_point             box;
    } t_box_answer;

    t_point      stored_pts [MAX_POINTS];
    int          stored_n = 0;
    t_point      top_idx;
    t_box_answer answers_due [$];
    int          errors = 0;
    int          checked = 0;

    function automatic t_box_answer predict_answer(input logic [CMD_W-1:0] cmd,
                                                   input t_point corner,
                                                   input t_order order);
        t_box_answer ans;
        t_point      p;
        logic        below;
        logic        at_or_below;
        int          memo;
        int          dim;
        ans = '0;
        case (cmd)
            CMD_CLEAR: begin
                stored_n = 0;
            end
            CMD_LOAD: begin
                if (stored_n >= MAX_POINTS) begin
                    ans.status = 1'b1;
                end else begin
                    stored_pts[stored_n] = corner;
                    stored_n++;
                end
            end
            CMD_QUERY: begin
                for (int i = 0; i < stored_n; i++) begin
                    p = stored_pts[i];
                    below = 1'b1;
                    at_or_below = 1'b1;
                    for (int d = 0; d < DIMENSIONS; d++) begin
                        if (p[d] >= corner[d]) below = 1'b0;
                        if (p[d] > corner[d]) at_or_below = 1'b0;
                    end
                    if (below) ans.open_n = ans.open_n + 1'b1;
                    if (at_or_below) begin
                        ans.closed_n = ans.closed_n + 1'b1;
                        // snapped corner: per-dimension max over the closed box
                        for (int d = 0; d < DIMENSIONS; d++) begin
                            if (p[d] > ans.box[d]) ans.box[d] = p[d];
                        end
                    end
                end
            end
            CMD_GROW: begin
                ans.box = top_idx;
                for (int i = 0; i < stored_n; i++) begin
                    p = stored_pts[i];
                    memo = -1;
                    for (int j = 0; j < DIMENSIONS; j++) begin
                        dim = int'(order[j]);
                        if (p[dim] >= corner[dim]) begin
                            if (p[dim] < ans.box[dim]) begin
                                if (memo < 0) memo = dim;
                            end else begin
                                // point blocks the box in this dimension: no shrink
                                memo = -1;
                                break;
                            end
                        end
                    end
                    if (memo >= 0) ans.box[memo] = p[memo];
                end
            end
        endcase
        return ans;
    endfunction

    task automatic flag_error(input string why, input t_box_answer want,
                              input t_box_answer got);
        errors++;
        if (errors <= REPORT_LIMIT) begin
            $display("bpc_checker: #%0d %s: want st=%0d open=%0d closed=%0d box=%0d,%0d,%0d,%0d",
                     checked, why, want.status, want.open_n, want.closed_n,
                     want.box[0], want.box[1], want.box[2], want.box[3]);
            $display("bpc_checker:   got st=%0d open=%0d closed=%0d box=%0d,%0d,%0d,%0d",
                     got.status, got.open_n, got.closed_n,
                     got.box[0], got.box[1], got.box[2], got.box[3]);
        end
    endtask

    always @(posedge i_clk) begin
        t_box_answer want;
        t_box_answer got;
        t_point      corner;
        t_order      order;
        logic        same;
        if (!i_rst_n) begin
            stored_n = 0;
            for (int d = 0; d < DIMENSIONS; d++) top_idx[d] = TOP_RESET;
            answers_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (int'(paddr) % REG_STRIDE == 0 && int'(paddr) / REG_STRIDE < DIMENSIONS)
                    top_idx[int'(paddr) / REG_STRIDE] = pwdata[INDEX_BITS-1:0];
            end

            // results first, so a result never meets the command of the same edge
            if (i_res_ch.valid && i_res_ch.ready) begin
                got.status   = i_res_ch.status;
                got.open_n   = i_res_ch.open_count;
                got.closed_n = i_res_ch.closed_count;
                got.box[0]   = i_res_ch.box_0;
                got.box[1]   = i_res_ch.box_1;
                got.box[2]   = i_res_ch.box_2;
                got.box[3]   = i_res_ch.box_3;
                if (answers_due.size() == 0) begin
                    flag_error("arrived with no command pending", '0, got);
                end else begin
                    want = answers_due.pop_front();
                    same = (got.status === want.status) && (got.open_n === want.open_n)
                           && (got.closed_n === want.closed_n);
                    for (int d = 0; d < DIMENSIONS; d++) begin
                        if (got.box[d] !== want.box[d]) same = 1'b0;
                    end
                    if (!same) flag_error("mismatch", want, got);
                end
                checked++;
            end

            if (i_cmd_ch.valid && i_cmd_ch.ready) begin
                corner[0] = i_cmd_ch.corner_0;
                corner[1] = i_cmd_ch.corner_1;
                corner[2] = i_cmd_ch.corner_2;
                corner[3] = i_cmd_ch.corner_3;
                order[0]  = i_cmd_ch.order_0;
                order[1]  = i_cmd_ch.order_1;
                order[2]  = i_cmd_ch.order_2;
                order[3]  = i_cmd_ch.order_3;
                answers_due.push_back(predict_answer(i_cmd_ch.command, corner, order));
            end
        end
        o_error_count <= errors;
        o_pending     <= answers_due.size();
        o_checked     <= checked;
    end

endmodule

[tb/tb.sv]
// tb: stimulus and verdict for the box point counter; drives command transfers
// in bursts, result stalls and APB top index writes, checking lives in bpc_checker
// depends on bpc_pkg, bpc_if, bpc_checker and box_point_count_snap_grow
module tb;
    import bpc_pkg::*;

    localparam int     REG_STRIDE      = 4;
    localparam int     PHASE_ITEMS     = 16;
    localparam int     IDLE_LIMIT      = 5000;
    localparam int     HOLD_OFF_AFTER  = 150;
    localparam int     HOLD_OFF_CYCLES = 600;
    localparam int     DRAIN_SETTLE    = 16;
    localparam t_index INDEX_MAX       = '1;
    localparam int     GRID_STEP       = 585;  // 7 steps land exactly on the top index

    typedef enum int {TOPS_RANDOM, TOPS_ZERO, TOPS_FULL, TOPS_MIXED, TOPS_GRID} t_tops_style;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int err_count;
    int pending;
    int checked;
    int items_sent = 0;
    int burst_left = 20;
    int tops_written = 0;
    int sent_by_cmd [1 << CMD_W];

    bpc_in_if  cmd_ch ();
    bpc_out_if res_ch ();

    box_point_count_snap_grow i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bpc_checker #(
        .MAX_POINTS (DEF_MAX_POINTS),
        .REG_STRIDE (REG_STRIDE)
    ) u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cmd_ch      (cmd_ch),
        .i_res_ch      (res_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .o_error_count (err_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic t_point mk_point(input int c0, input int c1, input int c2, input int c3);
        return {t_index'(c3), t_index'(c2), t_index'(c1), t_index'(c0)};
    endfunction

    function automatic t_order mk_order(input int o0, input int o1, input int o2, input int o3);
        return {ORDER_W'(o3), ORDER_W'(o2), ORDER_W'(o1), ORDER_W'(o0)};
    endfunction

    // mostly a coarse grid so that corners often equal stored coordinates
    function automatic t_index rand_coord();
        case ($urandom_range(0, 9))
            0:             return '0;
            1:             return INDEX_MAX;
            2, 3, 4, 5, 6: return t_index'($urandom_range(0, 7) * GRID_STEP);
            default:       return t_index'($urandom_range(0, (1 << INDEX_BITS) - 1));
        endcase
    endfunction

    function automatic t_point rand_point();
        t_point p;
        for (int d = 0; d < DIMENSIONS; d++) p[d] = rand_coord();
        return p;
    endfunction

    // mostly permutations, sometimes repeated or missing dimensions
    function automatic t_order rand_order();
        int     dims [DIMENSIONS];
        int     k;
        int     tmp;
        t_order o;
        for (int d = 0; d < DIMENSIONS; d++) dims[d] = d;
        for (int d = DIMENSIONS - 1; d > 0; d--) begin
            k = $urandom_range(0, d);
            tmp = dims[d];
            dims[d] = dims[k];
            dims[k] = tmp;
        end
        for (int d = 0; d < DIMENSIONS; d++) begin
            if ($urandom_range(0, 4) == 0) o[d] = ORDER_W'($urandom_range(0, DIMENSIONS - 1));
            else o[d] = ORDER_W'(dims[d]);
        end
        return o;
    endfunction

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input t_point corner, input t_order order);
        int gap;
        cmd_ch.valid    <= 1'b1;
        cmd_ch.command  <= cmd;
        cmd_ch.corner_0 <= corner[0];
        cmd_ch.corner_1 <= corner[1];
        cmd_ch.corner_2 <= corner[2];
        cmd_ch.corner_3 <= corner[3];
        cmd_ch.order_0  <= order[0];
        cmd_ch.order_1  <= order[1];
        cmd_ch.order_2  <= order[2];
        cmd_ch.order_3  <= order[3];
        do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
        items_sent++;
        sent_by_cmd[cmd]++;
        burst_left--;
        if (burst_left <= 0) begin
            case ($urandom_range(0, 3))
                0:       burst_left = $urandom_range(1, 3);
                1:       burst_left = $urandom_range(4, 16);
                default: burst_left = $urandom_range(16, 60);
            endcase
            case ($urandom_range(0, 7))
                0, 1, 2, 3: gap = $urandom_range(1, 3);
                4, 5:       gap = $urandom_range(4, 30);
                6:          gap = $urandom_range(30, 120);
                default:    gap = $urandom_range(120, 300);
            endcase
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_top_index(input int dim, input t_index value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(dim * REG_STRIDE);
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_top_indices(input t_tops_style style);
        t_index value;
        wait_all_results();
        for (int d = 0; d < DIMENSIONS; d++) begin
            case (style)
                TOPS_RANDOM: value = t_index'($urandom_range(0, (1 << INDEX_BITS) - 1));
                TOPS_ZERO:   value = '0;
                TOPS_FULL:   value = INDEX_MAX;
                TOPS_MIXED:  value = (d % 2 == 0) ? INDEX_MAX : rand_coord();
                default:     value = rand_coord();
            endcase
            write_top_index(d, value);
            tops_written++;
        end
    endtask

    task automatic run_phase(input t_tops_style style);
        int start;
        int loads;
        start = items_sent;
        set_top_indices(style);
        send_cmd(CMD_CLEAR, rand_point(), rand_order());
        // one phase runs the store past full so that loads get dropped
        loads = (style == TOPS_FULL) ? DEF_MAX_POINTS + 3 : $urandom_range(2, 24);
        repeat (loads) send_cmd(CMD_LOAD, rand_point(), rand_order());
        while (items_sent - start < PHASE_ITEMS + loads) begin
            case ($urandom_range(0, 15))
                0:                  send_cmd(CMD_CLEAR, rand_point(), rand_order());
                1, 2, 3, 4:         send_cmd(CMD_LOAD, rand_point(), rand_order());
                5, 6, 7, 8, 9:      send_cmd(CMD_QUERY, rand_point(), rand_order());
                10, 11, 12, 13, 14: send_cmd(CMD_GROW, rand_point(), rand_order());
                default:            wait_all_results();
            endcase
        end
    endtask

    // receiver: stretches of free flow, light and heavy stalls, one long hold-off
    initial begin
        int   mode;
        int   mode_left;
        int   hold_left;
        logic held;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        held = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!held && checked >= HOLD_OFF_AFTER) begin
                held = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: res_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: no transfer for %0d cycles", IDLE_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        for (int c = 0; c < (1 << CMD_W); c++) sent_by_cmd[c] = 0;
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.command  <= CMD_CLEAR;
        cmd_ch.corner_0 <= '0;
        cmd_ch.corner_1 <= '0;
        cmd_ch.corner_2 <= '0;
        cmd_ch.corner_3 <= '0;
        cmd_ch.order_0  <= '0;
        cmd_ch.order_1  <= '0;
        cmd_ch.order_2  <= '0;
        cmd_ch.order_3  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, boundaries of open and closed boxes, grow orders
        send_cmd(CMD_QUERY, mk_point(4095, 4095, 4095, 4095), mk_order(0, 1, 2, 3));
        send_cmd(CMD_GROW, mk_point(0, 0, 0, 0), mk_order(0, 1, 2, 3));
        send_cmd(CMD_LOAD, mk_point(0, 0, 0, 0), mk_order(0, 0, 0, 0));
        send_cmd(CMD_LOAD, mk_point(4095, 4095, 4095, 4095), mk_order(3, 3, 3, 3));
        send_cmd(CMD_LOAD, mk_point(5, 10, 4095, 0), mk_order(0, 0, 0, 0));
        send_cmd(CMD_LOAD, mk_point(100, 200, 300, 400), mk_order(0, 0, 0, 0));
        send_cmd(CMD_LOAD, mk_point(100, 200, 300, 400), mk_order(0, 0, 0, 0));
        send_cmd(CMD_QUERY, mk_point(0, 0, 0, 0), mk_order(0, 0, 0, 0));
        send_cmd(CMD_QUERY, mk_point(4095, 4095, 4095, 4095), mk_order(0, 0, 0, 0));
        send_cmd(CMD_QUERY, mk_point(100, 200, 300, 400), mk_order(0, 0, 0, 0));
        send_cmd(CMD_QUERY, mk_point(99, 4095, 4095, 4095), mk_order(0, 0, 0, 0));
        send_cmd(CMD_GROW, mk_point(0, 0, 0, 0), mk_order(0, 1, 2, 3));
        send_cmd(CMD_GROW, mk_point(0, 0, 0, 0), mk_order(3, 2, 1, 0));
        send_cmd(CMD_GROW, mk_point(50, 50, 50, 50), mk_order(1, 1, 2, 2));
        send_cmd(CMD_GROW, mk_point(4095, 4095, 4095, 4095), mk_order(0, 1, 2, 3));
        send_cmd(CMD_GROW, mk_point(6, 0, 0, 0), mk_order(0, 3, 0, 3));
        send_cmd(CMD_CLEAR, mk_point(4095, 4095, 4095, 4095), mk_order(3, 3, 3, 3));
        send_cmd(CMD_QUERY, mk_point(4095, 4095, 4095, 4095), mk_order(0, 0, 0, 0));
        send_cmd(CMD_GROW, mk_point(0, 0, 0, 0), mk_order(2, 0, 3, 1));
        send_cmd(CMD_LOAD, mk_point(4095, 0, 4095, 0), mk_order(0, 0, 0, 0));
        send_cmd(CMD_QUERY, mk_point(4095, 0, 4095, 0), mk_order(0, 0, 0, 0));
        send_cmd(CMD_GROW, mk_point(0, 0, 0, 0), mk_order(0, 1, 2, 3));

        run_phase(TOPS_RANDOM);
        run_phase(TOPS_ZERO);
        run_phase(TOPS_FULL);
        run_phase(TOPS_MIXED);
        run_phase(TOPS_GRID);

        wait_all_results();
        repeat (DRAIN_SETTLE) @(posedge clk);

        $display("summary: %0d commands (%0d clear, %0d load, %0d query, %0d grow), %0d checked",
                 items_sent, sent_by_cmd[CMD_CLEAR], sent_by_cmd[CMD_LOAD],
                 sent_by_cmd[CMD_QUERY], sent_by_cmd[CMD_GROW], checked);
        $display("summary: %0d top index writes (zero, full, mixed, random); store overfilled once",
                 tops_written);
        if (err_count == 0 && pending == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/bpc_pkg.sv
sv/bpc_if.sv
sv/bpc_regs.sv
sv/bpc_store.sv
sv/bpc_core.sv
sv/box_point_count_snap_grow.sv
tb/bpc_checker.sv
tb/tb.sv
